>>> sv/chd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chd_pkg
// Shared types, widths and codes of the canonical Huffman decoder.
// ----------------------------------------------------------------------------
package chd_pkg;

  // Default sizes
  localparam int SYMBOL_BITS_DEF  = 9;
  localparam int MAX_SYMBOLS_DEF  = 512;
  localparam int MAX_CODE_LEN_DEF = 32;

  // Fixed field widths
  localparam int WORD_W   = 9;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = 10;   // codes per length
  localparam int FC_W     = 64;   // first canonical code, wraps like a 64-bit word
  localparam int ENT_A_W  = 16;   // widest store address
  localparam int ENT_D_W  = 16;   // widest symbol

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_HDR_ERR  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_CODE_ERR = 2'd2;

  // Header phases
  localparam logic [1:0] PH_COUNT = 2'd0;
  localparam logic [1:0] PH_SYMS  = 2'd1;
  localparam logic [1:0] PH_LENS  = 2'd2;
  localparam logic [1:0] PH_READY = 2'd3;

  // Queue entry kinds
  localparam logic [1:0] ENT_WRITE  = 2'd0;  // store a header symbol
  localparam logic [1:0] ENT_READ   = 2'd1;  // emit a symbol from the store
  localparam logic [1:0] ENT_RESULT = 2'd2;  // emit symbol zero with a status

  typedef struct packed {
    logic [1:0]          kind;
    logic [ENT_A_W-1:0]  addr;
    logic [ENT_D_W-1:0]  data;
    logic [STATUS_W-1:0] status;
  } chd_entry_t;

endpackage
`default_nettype wire

>>> sv/chd_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chd_front
// Header parser, per-length code tables and bit-wise code matcher.
// ----------------------------------------------------------------------------
module chd_front
  import chd_pkg::*;
#(
  parameter int SYMBOL_BITS  = SYMBOL_BITS_DEF,
  parameter int MAX_SYMBOLS  = MAX_SYMBOLS_DEF,
  parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              accept,
  input  wire              in_mode,
  input  wire [WORD_W-1:0] in_word,
  input  wire              in_bit_req,
  output logic             push,
  output chd_entry_t       push_entry
);

  localparam int LOAD_W = $clog2(MAX_SYMBOLS + (1 << WORD_W) + 1);
  localparam int LEN_W  = $clog2(MAX_CODE_LEN);

  logic [1:0]              phase_r, phase_nxt;
  logic [LOAD_W-1:0]       total_r, total_nxt;
  logic [LOAD_W-1:0]       loaded_r, loaded_nxt;
  logic [LEN_W-1:0]        len_r, len_nxt;
  logic [MAX_CODE_LEN-1:0] acc_r, acc_nxt;
  logic [FC_W-1:0]         code_r, code_nxt;
  logic [LOAD_W-1:0]       base_r, base_nxt;
  logic [MAX_CODE_LEN-1:0] lc_valid_r, lc_valid_nxt;
  logic                    tbl_wr;

  logic [CNT_W-1:0]  lc_r  [MAX_CODE_LEN];
  logic [FC_W-1:0]   fc_r  [MAX_CODE_LEN];
  logic [LOAD_W-1:0] off_r [MAX_CODE_LEN];

  logic [LOAD_W-1:0]       word_ext;
  logic [LOAD_W-1:0]       sum;
  logic [MAX_CODE_LEN-1:0] acc_sh;
  logic [FC_W-1:0]         delta;
  logic [CNT_W-1:0]        cnt;
  logic                    hit;
  logic [LOAD_W-1:0]       idx;
  logic [ENT_D_W-1:0]      sym_mask;

  assign word_ext = LOAD_W'(in_word);
  assign sum      = loaded_r + word_ext;
  assign acc_sh   = {acc_r[MAX_CODE_LEN-2:0], in_bit_req};
  assign cnt      = lc_valid_r[len_r] ? lc_r[len_r] : '0;
  assign delta    = FC_W'(acc_sh) - fc_r[len_r];
  assign hit      = (FC_W'(acc_sh) >= fc_r[len_r]) && (delta[FC_W-1:CNT_W] == '0) &&
                    (delta[CNT_W-1:0] < cnt);
  assign idx      = off_r[len_r] + LOAD_W'(delta[CNT_W-1:0]);
  assign sym_mask = ENT_D_W'((32'd1 << SYMBOL_BITS) - 32'd1);

  // Classify the item and update header and decode state
  always_comb begin
    phase_nxt    = phase_r;
    total_nxt    = total_r;
    loaded_nxt   = loaded_r;
    len_nxt      = len_r;
    acc_nxt      = acc_r;
    code_nxt     = code_r;
    base_nxt     = base_r;
    lc_valid_nxt = lc_valid_r;
    tbl_wr       = 1'b0;
    push         = 1'b0;
    push_entry   = '0;
    if (accept) begin
      if (!in_mode) begin
        unique case (phase_r)
          PH_COUNT, PH_READY: begin
            lc_valid_nxt = '0;
            loaded_nxt   = '0;
            len_nxt      = '0;
            acc_nxt      = '0;
            code_nxt     = '0;
            base_nxt     = '0;
            total_nxt    = (word_ext > LOAD_W'(MAX_SYMBOLS)) ? LOAD_W'(MAX_SYMBOLS) : word_ext;
            phase_nxt    = (total_nxt == '0) ? PH_READY : PH_SYMS;
          end
          PH_SYMS: begin
            if (loaded_r < LOAD_W'(MAX_SYMBOLS)) begin
              push            = 1'b1;
              push_entry.kind = ENT_WRITE;
              push_entry.addr = ENT_A_W'(loaded_r);
              push_entry.data = ENT_D_W'(in_word) & sym_mask;
            end
            loaded_nxt = loaded_r + LOAD_W'(1);
            if (loaded_nxt >= total_r) begin
              loaded_nxt = '0;
              len_nxt    = '0;
              phase_nxt  = PH_LENS;
            end
          end
          default: begin
            // Length counts: record this length and advance the canonical code
            tbl_wr                = 1'b1;
            lc_valid_nxt[len_r]   = 1'b1;
            code_nxt              = (code_r + FC_W'(in_word)) << 1;
            base_nxt              = base_r + word_ext;
            if (sum == total_r) begin
              len_nxt   = '0;
              acc_nxt   = '0;
              phase_nxt = PH_READY;
            end else if (sum > total_r || len_r == LEN_W'(MAX_CODE_LEN - 1)) begin
              lc_valid_nxt      = '0;
              loaded_nxt        = '0;
              len_nxt           = '0;
              acc_nxt           = '0;
              phase_nxt         = PH_COUNT;
              push              = 1'b1;
              push_entry.kind   = ENT_RESULT;
              push_entry.status = ST_HDR_ERR;
            end else begin
              loaded_nxt = sum;
              len_nxt    = len_r + LEN_W'(1);
            end
          end
        endcase
      end else if (phase_r == PH_READY) begin
        // Code bit: match against the range of the current length
        if (hit) begin
          push     = 1'b1;
          len_nxt  = '0;
          acc_nxt  = '0;
          if (idx < LOAD_W'(MAX_SYMBOLS)) begin
            push_entry.kind = ENT_READ;
            push_entry.addr = ENT_A_W'(idx);
          end else begin
            push_entry.kind   = ENT_RESULT;
            push_entry.status = ST_OK;
          end
        end else if (len_r == LEN_W'(MAX_CODE_LEN - 1)) begin
          push              = 1'b1;
          push_entry.kind   = ENT_RESULT;
          push_entry.status = ST_CODE_ERR;
          len_nxt           = '0;
          acc_nxt           = '0;
        end else begin
          len_nxt = len_r + LEN_W'(1);
          acc_nxt = acc_sh;
        end
      end
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_COUNT;
      total_r    <= '0;
      loaded_r   <= '0;
      len_r      <= '0;
      acc_r      <= '0;
      code_r     <= '0;
      base_r     <= '0;
      lc_valid_r <= '0;
    end else begin
      phase_r    <= phase_nxt;
      total_r    <= total_nxt;
      loaded_r   <= loaded_nxt;
      len_r      <= len_nxt;
      acc_r      <= acc_nxt;
      code_r     <= code_nxt;
      base_r     <= base_nxt;
      lc_valid_r <= lc_valid_nxt;
    end
  end

  // Write per-length tables
  always_ff @(posedge clk) begin
    if (tbl_wr) begin
      lc_r[len_r]  <= CNT_W'(in_word);
      fc_r[len_r]  <= code_r;
      off_r[len_r] <= base_r;
    end
  end

endmodule
`default_nettype wire

>>> sv/chd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chd_queue
// Short entry queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module chd_queue
  import chd_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  wire        push,
  input  chd_entry_t push_entry,
  input  wire        pop,
  output chd_entry_t head,
  output logic       empty,
  output logic       full
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  chd_entry_t        slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_QW-1:0] count_r;

  assign head  = slot_r[rd_ptr_r];
  assign empty = (count_r == '0);
  assign full  = (count_r == CNT_QW'(QUEUE_DEPTH));

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      count_r <= count_r + CNT_QW'(push) - CNT_QW'(pop);
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_entry;
  end

endmodule
`default_nettype wire

>>> sv/chd_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chd_back
// Symbol store and result register; executes queue entries in order.
// ----------------------------------------------------------------------------
module chd_back
  import chd_pkg::*;
#(
  parameter int SYMBOL_BITS = SYMBOL_BITS_DEF,
  parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  chd_entry_t             head,
  input  wire                    empty,
  output logic                   pop,
  output logic                   out_valid,
  input  wire                    out_stall,
  output logic [SYMBOL_BITS-1:0] out_symbol,
  output logic [STATUS_W-1:0]    out_status
);

  localparam int ADDR_W = $clog2(MAX_SYMBOLS);

  logic [SYMBOL_BITS-1:0] mem_r [MAX_SYMBOLS];
  logic [SYMBOL_BITS-1:0] rd_data_r;
  logic                   out_valid_r;
  logic [STATUS_W-1:0]    status_r;
  logic                   use_mem_r;
  logic                   taken;
  logic                   is_write;

  assign taken      = out_valid_r && !out_stall;
  assign is_write   = (head.kind == ENT_WRITE);
  assign pop        = !empty && (is_write || !out_valid_r || !out_stall);
  assign out_valid  = out_valid_r;
  assign out_status = status_r;
  assign out_symbol = use_mem_r ? rd_data_r : '0;

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop && !is_write) begin
      out_valid_r <= 1'b1;
    end else if (taken) begin
      out_valid_r <= 1'b0;
    end
  end

  // Load payload of a new result
  always_ff @(posedge clk) begin
    if (pop && !is_write) begin
      status_r  <= head.status;
      use_mem_r <= (head.kind == ENT_READ);
    end
  end

  // Symbol store: write header symbols, read on lookup
  always_ff @(posedge clk) begin
    if (pop && is_write) mem_r[head.addr[ADDR_W-1:0]] <= head.data[SYMBOL_BITS-1:0];
    if (pop && head.kind == ENT_READ) rd_data_r <= mem_r[head.addr[ADDR_W-1:0]];
  end

endmodule
`default_nettype wire

>>> sv/canonical_huffman_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// canonical_huffman_decoder
// Loads a canonical Huffman header and decodes code bits to symbols.
// ----------------------------------------------------------------------------
// A result is pushed into the entry queue, then loaded into the result register.
// Throughput: one item per cycle while in_stall is low, header words and code bits
//   alike; per-length range check and registered symbol store read set the rate.
// Reset: header expects a symbol count, length tables read as empty;
//   the symbol store is not cleared and holds garbage until loaded.
module canonical_huffman_decoder
  import chd_pkg::*;
#(
  parameter int SYMBOL_BITS  = SYMBOL_BITS_DEF,
  parameter int MAX_SYMBOLS  = MAX_SYMBOLS_DEF,
  parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_stall,
  input  wire                    in_mode,
  input  wire [WORD_W-1:0]       in_word,
  input  wire                    in_bit_req,
  output logic                   out_valid,
  input  wire                    out_stall,
  output logic [SYMBOL_BITS-1:0] out_symbol,
  output logic [STATUS_W-1:0]    out_status
);

  logic       accept;
  logic       push;
  chd_entry_t push_entry;
  logic       pop;
  chd_entry_t head;
  logic       empty;
  logic       full;

  // Stall input while the queue is full
  assign in_stall = full;
  assign accept   = in_valid && !full;

  chd_front #(
    .SYMBOL_BITS (SYMBOL_BITS),
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .MAX_CODE_LEN(MAX_CODE_LEN)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_mode   (in_mode),
    .in_word   (in_word),
    .in_bit_req(in_bit_req),
    .push      (push),
    .push_entry(push_entry)
  );

  chd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .full      (full)
  );

  chd_back #(
    .SYMBOL_BITS(SYMBOL_BITS),
    .MAX_SYMBOLS(MAX_SYMBOLS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_symbol(out_symbol),
    .out_status(out_status)
  );

endmodule
`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the canonical Huffman decoder: headers with random contents, code
// bits for random symbols, broken headers and noise, with results compared
// field by field against an in-bench decoder under random input and output
// idling.
// ----------------------------------------------------------------------------
module tb;
  import chd_pkg::*;

  localparam int NSYM = 512;
  localparam int NLEN = 32;

  typedef struct {
    logic       mode;
    logic [8:0] word;
    logic       bit_req;
    bit         drain;    // wait for all results before sending this item
  } item_t;

  typedef struct {
    logic [8:0] symbol;
    logic [1:0] status;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_mode = 1'b0;
  logic [WORD_W-1:0] in_word = '0;
  logic in_bit_req = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [8:0] out_symbol;
  logic [STATUS_W-1:0] out_status;

  item_t   pending_items[$];
  result_t decoded_fifo[$];
  int      fail_count = 0;
  int      results_seen = 0;

  // Decoder state for prediction
  logic [8:0]      dec_store[NSYM];
  int unsigned     dec_count[NLEN];
  longint unsigned dec_first[NLEN];
  int unsigned     dec_base[NLEN];
  logic [1:0]      dec_phase = PH_COUNT;
  int unsigned     dec_total = 0;
  int unsigned     dec_loaded = 0;
  int unsigned     dec_len = 0;
  longint unsigned dec_acc = 0;

  // Stimulus-side code tables of the header being built
  int unsigned gen_count[NLEN];
  int unsigned gen_nlen;

  always #1 clk = ~clk;

  canonical_huffman_decoder i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_mode    (in_mode),
    .in_word    (in_word),
    .in_bit_req (in_bit_req),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_symbol (out_symbol),
    .out_status (out_status)
  );

  function automatic void clear_decoder();
    for (int k = 0; k < NLEN; k++) begin
      dec_count[k] = 0;
      dec_first[k] = 0;
      dec_base[k] = 0;
    end
    dec_loaded = 0;
    dec_len = 0;
    dec_acc = 0;
  endfunction

  function automatic void build_decoder();
    longint unsigned code;
    int unsigned base;
    code = 0;
    base = 0;
    for (int k = 0; k < NLEN; k++) begin
      dec_first[k] = code;
      dec_base[k] = base;
      base += dec_count[k];
      code = (code + longint'(dec_count[k])) << 1;
    end
    dec_len = 0;
    dec_acc = 0;
    dec_phase = PH_READY;
  endfunction

  function automatic void push_result(logic [8:0] sym, logic [1:0] st);
    result_t r;
    r.symbol = sym;
    r.status = st;
    decoded_fifo.push_back(r);
  endfunction

  // Advance the decoder by one accepted item
  function automatic void decode_item(item_t it);
    int unsigned k;
    longint unsigned delta;
    longint unsigned idx;
    k = 0;
    if (it.mode == 1'b0) begin
      if (dec_phase == PH_READY) dec_phase = PH_COUNT;
      if (dec_phase == PH_COUNT) begin
        clear_decoder();
        dec_total = (it.word > NSYM) ? NSYM : it.word;
        if (dec_total == 0) build_decoder();
        else dec_phase = PH_SYMS;
      end else if (dec_phase == PH_SYMS) begin
        if (dec_loaded < NSYM) dec_store[dec_loaded] = it.word;
        dec_loaded++;
        if (dec_loaded >= dec_total) begin
          dec_loaded = 0;
          dec_len = 0;
          dec_phase = PH_LENS;
        end
      end else begin
        if (dec_len < NLEN) dec_count[dec_len] = it.word;
        dec_len++;
        dec_loaded += it.word;
        if (dec_loaded == dec_total) begin
          build_decoder();
        end else if (dec_loaded > dec_total || dec_len >= NLEN) begin
          clear_decoder();
          dec_phase = PH_COUNT;
          push_result('0, ST_HDR_ERR);
        end
      end
      return;
    end
    if (dec_phase != PH_READY) return;
    dec_acc = (dec_acc << 1) | longint'(it.bit_req);
    k = dec_len;
    if (k >= NLEN) begin
      dec_len = 0;
      dec_acc = 0;
      push_result('0, ST_CODE_ERR);
      return;
    end
    dec_len++;
    if (dec_acc >= dec_first[k]) begin
      delta = dec_acc - dec_first[k];
      if (delta < longint'(dec_count[k])) begin
        idx = longint'(dec_base[k]) + delta;
        dec_len = 0;
        dec_acc = 0;
        push_result(idx < NSYM ? dec_store[idx] : 9'd0, ST_OK);
        return;
      end
    end
    if (dec_len >= NLEN) begin
      dec_len = 0;
      dec_acc = 0;
      push_result('0, ST_CODE_ERR);
    end
  endfunction

  // Queue helpers for stimulus
  function automatic void add_word(logic [8:0] w, bit drain = 0);
    item_t it;
    it.mode = 1'b0;
    it.word = w;
    it.bit_req = $urandom_range(0, 1);
    it.drain = drain;
    pending_items.push_back(it);
  endfunction

  function automatic void add_bit(logic b);
    item_t it;
    it.mode = 1'b1;
    it.word = $urandom_range(0, 511);
    it.bit_req = b;
    it.drain = 0;
    pending_items.push_back(it);
  endfunction

  // Split n symbols over code lengths, leaving room for the tree to close
  function automatic void plan_lengths(int unsigned n);
    int unsigned avail;
    int unsigned left;
    int unsigned c;
    avail = 2;
    left = n;
    gen_nlen = 0;
    for (int k = 0; k < NLEN; k++) gen_count[k] = 0;
    while (left > 0) begin
      // Past the middle lengths, let the free codes double so all fit in time
      if (left <= avail) c = left;
      else if (gen_nlen >= 16) c = 0;
      else c = $urandom_range(0, (avail - 1 < left - 1) ? avail - 1 : left - 1);
      gen_count[gen_nlen] = c;
      left -= c;
      avail = (avail - c) * 2;
      gen_nlen++;
    end
  endfunction

  function automatic void add_header(int unsigned n, bit drain = 0);
    add_word(n, drain);
    for (int i = 0; i < n; i++) add_word($urandom_range(0, 511));
    for (int k = 0; k < gen_nlen; k++) add_word(gen_count[k]);
  endfunction

  // Send the canonical code of symbol index sel
  function automatic void add_code(int unsigned sel);
    longint unsigned code;
    int unsigned base;
    code = 0;
    base = 0;
    for (int k = 0; k < gen_nlen; k++) begin
      if (sel < base + gen_count[k]) begin
        code = code + (sel - base);
        for (int b = k; b >= 0; b--) add_bit(code[b]);
        return;
      end
      base += gen_count[k];
      code = (code + gen_count[k]) << 1;
    end
  endfunction

  // Driver: offer queued items with random gaps, bursts without gaps
  int  send_gap = 0;
  int  sent_items = 0;
  bit  send_burst = 0;
  always @(posedge clk) begin
    bit fire;
    bit next_valid;
    item_t it;
    fire = in_valid && !in_stall;
    next_valid = in_valid && !fire;
    if (!rst_n) begin
      next_valid = 0;
    end else begin
      if (fire) begin
        decode_item('{in_mode, in_word, in_bit_req, 0});
        sent_items++;
        if (sent_items % 150 == 0) send_burst = ($urandom_range(0, 2) == 0);
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_items.size() > 0 &&
                     !(pending_items[0].drain && decoded_fifo.size() > 0)) begin
          it = pending_items.pop_front();
          in_mode <= it.mode;
          in_word <= it.word;
          in_bit_req <= it.bit_req;
          next_valid = 1;
          send_gap = send_burst ? 0 : $urandom_range(0, 10);
        end
      end
    end
    in_valid <= next_valid;
  end

  // Long receiver hold-off, counted on its own
  logic long_hold = 1'b0;
  int   hold_left = 0;
  bit   hold_done = 0;
  always @(posedge clk) begin
    if (!hold_done && results_seen >= 300) begin
      hold_done = 1;
      hold_left = 300;
    end
    if (hold_left > 0) hold_left--;
    long_hold <= (hold_left > 0);
  end

  // Monitor: check each accepted result, draw the next stall
  int  recv_wait = 0;
  bit  recv_burst = 0;
  always @(posedge clk) begin
    result_t exp_r;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (results_seen % 100 == 0) recv_burst = ($urandom_range(0, 2) == 0);
        if (decoded_fifo.size() == 0) begin
          $error("unexpected result symbol=%0d status=%0d", out_symbol, out_status);
          fail_count++;
        end else begin
          exp_r = decoded_fifo.pop_front();
          if (out_symbol !== exp_r.symbol) begin
            $error("symbol: expected %0d, got %0d", exp_r.symbol, out_symbol);
            fail_count++;
          end
          if (out_status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, out_status);
            fail_count++;
          end
        end
        recv_wait = recv_burst ? 0 : $urandom_range(0, 10);
      end else if (recv_wait > 0) begin
        recv_wait--;
      end
    end
    out_stall <= long_hold || (recv_wait > 0);
  end

  // Stimulus and end of run
  initial begin
    int unsigned n;
    // Empty header, then an overlong code and one more bit
    plan_lengths(0);
    add_word(0);
    for (int i = 0; i < 33; i++) add_bit($urandom_range(0, 1));
    // Two-symbol header, one value all ones, then both codes
    add_word(2, 1);
    add_word(9'h1ff);
    add_word(9'h155);
    add_word(2);
    add_bit(0);
    add_bit(1);
    // Oversubscribed lengths: three codes of length one
    add_word(3);
    add_word(9'h0aa);
    add_word(9'h100);
    add_word(9'h001);
    add_word(3);
    add_bit(0);
    add_bit(1);
    // Code bit during the header is ignored; overshoot gives a header error
    add_word(4);
    add_bit(1);
    add_word(5);
    add_word(6);
    add_word(7);
    add_word(8);
    add_word(9'h1ff);
    // Lengths exhausted: all counts zero
    add_word(1);
    add_word(3);
    for (int k = 0; k < NLEN; k++) add_word(0);
    // Largest header, a few codes from it
    plan_lengths(511);
    add_header(511);
    for (int i = 0; i < 8; i++) add_code($urandom_range(0, 510));
    add_code(0);
    add_code(510);

    // Random part
    while (pending_items.size() < 1250) begin
      case ($urandom_range(0, 9))
        0: begin
          // Broken header: overshoot or exhausted lengths
          n = $urandom_range(1, 6);
          add_word(n);
          for (int i = 0; i < n; i++) add_word($urandom_range(0, 511));
          if ($urandom_range(0, 1)) add_word($urandom_range(n + 1, 511));
          else for (int k = 0; k < NLEN; k++) add_word(0);
        end
        1: begin
          // Noise items of either kind
          for (int i = 0; i < 10; i++) begin
            if ($urandom_range(0, 1)) add_bit($urandom_range(0, 1));
            else add_word($urandom_range(0, 511));
          end
        end
        default: begin
          n = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 200)
                                           : $urandom_range(1, 12);
          plan_lengths(n);
          add_header(n, $urandom_range(0, 20) == 0);
          if (n == 0) begin
            for (int i = 0; i < 32; i++) add_bit($urandom_range(0, 1));
          end else begin
            for (int i = 0; i < $urandom_range(5, 25); i++) begin
              if ($urandom_range(0, 9) == 0) add_bit($urandom_range(0, 1));
              else add_code($urandom_range(0, n - 1));
            end
          end
        end
      endcase
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_items.size() == 0 && !in_valid);
    wait (decoded_fifo.size() == 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && decoded_fifo.size() == 0) begin
      $display("[canonical_huffman_decoder] OK");
    end else begin
      $display("[canonical_huffman_decoder] ERROR");
    end
    $finish;
  end

  // Run limit
  initial begin
    #2000000;
    $display("[canonical_huffman_decoder] ERROR");
    $finish;
  end

endmodule
